/* sv/sptc_pkg.sv */
// ----------------------------------------------------------------------------
// sptc_pkg
// Shared widths, constants, register indexes, sequencer states and the
// multiply-accumulate operation type of the slip PID traction controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sptc_pkg;

  localparam int SPEED_W      = 16;
  localparam int TARGET_W     = 14;
  localparam int GAIN_W       = 16;
  localparam int SLIP_W       = 17;
  localparam int ERR_W        = 17;
  localparam int DERR_W       = 18;
  localparam int PID_W        = 32;
  localparam int INTEG_W      = 32;
  localparam int TORQUE_W     = 24;
  localparam int QUOT_W       = 15;
  localparam int MUL_A_W      = 17;
  localparam int MUL_B_W      = 33;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int ACC_W        = 44;
  localparam int GAIN_SHIFT   = 6;
  localparam int TORQUE_SHIFT = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SLIP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_CAP  = 3'd4;

  localparam logic [TARGET_W-1:0] TARGET_SLIP_RST = 14'd1638;
  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd123;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = 16'd61;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 16'd4467;
  localparam logic [GAIN_W-1:0]   TORQUE_CAP_RST  = 16'd2300;

  localparam logic signed [SLIP_W-1:0] SLIP_ZERO_WHEEL = 17'sd2;
  localparam logic signed [SLIP_W-1:0] SLIP_MIN        = -17'sd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_PID,
    ST_MUL_T,
    ST_TQ_WAIT,
    ST_OUT
  } sptc_state_t;

  typedef struct packed {
    logic en;
    logic clear;
    logic wide;
  } mac_op_t;

endpackage

`default_nettype wire

/* sv/sptc_in_if.sv */
// ----------------------------------------------------------------------------
// sptc_in_if
// Speed sample channel: valid, ready, wheel and vehicle speed.
// ----------------------------------------------------------------------------
`default_nettype none

interface sptc_in_if;
  import sptc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] wheel_speed;
  logic [SPEED_W-1:0] vehicle_speed;

  modport source (output valid, output wheel_speed, output vehicle_speed, input ready);
  modport sink (input valid, input wheel_speed, input vehicle_speed, output ready);
endinterface

`default_nettype wire

/* sv/sptc_out_if.sv */
// ----------------------------------------------------------------------------
// sptc_out_if
// Control result channel: valid, ready, torque, pid value and slip error.
// ----------------------------------------------------------------------------
`default_nettype none

interface sptc_out_if;
  import sptc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [TORQUE_W-1:0] drive_torque;
  logic signed [PID_W-1:0]    pid_value;
  logic signed [ERR_W-1:0]    slip_error;

  modport source (output valid, output drive_torque, output pid_value, output slip_error,
                  input ready);
  modport sink (input valid, input drive_torque, input pid_value, input slip_error,
                output ready);
endinterface

`default_nettype wire

/* sv/sptc_div.sv */
// ----------------------------------------------------------------------------
// sptc_div
// Restoring divider, one quotient bit per cycle, for the slip ratio
// |wheel - vehicle| * 2^14 / wheel with a dividend below twice the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module sptc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sptc_pkg::SPEED_W:0]     dividend,
  input  logic [sptc_pkg::SPEED_W-1:0]   divisor,
  output logic                           done,
  output logic [sptc_pkg::QUOT_W-1:0]    quot
);
  import sptc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [SPEED_W:0]     rem_r;
  logic [QUOT_W-1:0]    q_r;
  logic [SPEED_W-1:0]   dvs_r;
  logic [SPEED_W+1:0]   trial;
  logic                 ge;

  always_comb begin
    trial = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge    = trial >= {2'b00, dvs_r};
    done  = busy_r && (cnt_r == CNT_LAST);
    quot  = {q_r[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (SPEED_W+1)'(trial - {2'b00, dvs_r}) : (SPEED_W+1)'(trial);
      q_r   <= quot;
    end
  end

endmodule

`default_nettype wire

/* sv/sptc_mac.sv */
// ----------------------------------------------------------------------------
// sptc_mac
// Shared multiply-accumulate unit: registered signed product, then an
// accumulate of the product shifted down by the gain or torque scale.
// ----------------------------------------------------------------------------
`default_nettype none

module sptc_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sptc_pkg::mac_op_t                   op,
  input  logic signed [sptc_pkg::MUL_A_W-1:0] a,
  input  logic signed [sptc_pkg::MUL_B_W-1:0] b,
  output logic signed [sptc_pkg::ACC_W-1:0]   acc
);
  import sptc_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  mac_op_t                  pend_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [ACC_W-1:0]  base;

  always_comb begin
    scaled = pend_r.wide ? ACC_W'(prod_r >>> TORQUE_SHIFT) : ACC_W'(prod_r >>> GAIN_SHIFT);
    base   = pend_r.clear ? '0 : acc_r;
    acc    = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod_r <= a * b;
    end
    if (pend_r.en) begin
      acc_r <= base + scaled;
    end
  end

endmodule

`default_nettype wire

/* sv/slip_pid_traction_control_unit.sv */
// ----------------------------------------------------------------------------
// slip_pid_traction_control_unit
// Slip-ratio PID traction controller: serial slip division, error and
// saturating integral, then P, I, D and torque on one shared multiplier.
//
//   channel  dir  payload                                   handshake
//   in_ch    in   wheel_speed, vehicle_speed                valid/ready
//   out_ch   out  drive_torque, pid_value, slip_error       valid/ready
//   cfg_*    in   cfg_index, cfg_data                       cfg_we, no wait
//
// A transaction takes the 15 restoring divider steps and four passes through
// the one multiplier; the divider is skipped when the wheel speed is zero or
// the slip saturates.
// rst_n is synchronous; it restores register defaults and clears the
// integral and the previous error.
// a waiting result does not block the next input; a new result waits in
// the final state until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_pid_traction_control_unit #(
  parameter int SPEED_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sptc_in_if.sink                            in_ch,
  sptc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [sptc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sptc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sptc_pkg::*;

  localparam int USE_BITS = (SPEED_BITS < SPEED_W) ? SPEED_BITS : SPEED_W;
  localparam logic [SPEED_W-1:0] SPEED_MASK = SPEED_W'((64'd1 << USE_BITS) - 64'd1);

  sptc_state_t state_r, state_nxt;

  logic [TARGET_W-1:0] target_r;
  logic [GAIN_W-1:0]   kp_r, ki_r, kd_r, cap_r;

  logic [SPEED_W-1:0]         wheel_r, vehicle_r;
  logic                       neg_r;
  logic signed [SLIP_W-1:0]   slip_r;
  logic signed [ERR_W-1:0]    err_r, last_r;
  logic signed [INTEG_W-1:0]  integ_r;
  logic signed [PID_W-1:0]    pid_r;

  logic                       out_valid_r;
  logic signed [TORQUE_W-1:0] torque_r;
  logic signed [PID_W-1:0]    pid_out_r;
  logic signed [ERR_W-1:0]    err_out_r;

  logic signed [SPEED_W:0]    diff;
  logic [SPEED_W:0]           abs_diff;
  logic                       slip_sat;
  logic                       div_start, div_done;
  logic [QUOT_W-1:0]          quot;
  logic signed [SLIP_W-1:0]   quot_s;
  logic signed [ERR_W-1:0]    err_new;
  logic signed [INTEG_W:0]    integ_sum;
  logic signed [INTEG_W-1:0]  integ_new;
  logic signed [DERR_W-1:0]   derr;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PID_W-1:0]    pid_sat;
  logic signed [TORQUE_W-1:0] torque_new;
  logic                       out_free;
  logic                       in_ready;
  mac_op_t                    mac_op;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;

  // slip sign, magnitude and saturation
  always_comb begin
    diff     = $signed({1'b0, wheel_r}) - $signed({1'b0, vehicle_r});
    abs_diff = diff[SPEED_W] ? (SPEED_W+1)'(-diff) : (SPEED_W+1)'(diff);
    slip_sat = diff[SPEED_W] && ({1'b0, abs_diff} >= {1'b0, wheel_r, 1'b0});
    quot_s   = $signed({{(SLIP_W-QUOT_W){1'b0}}, quot});
  end

  // error, integral and derivative difference
  always_comb begin
    err_new   = $signed({{(ERR_W-TARGET_W){1'b0}}, target_r}) - slip_r;
    integ_sum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err_r);
    if (integ_sum[INTEG_W] == integ_sum[INTEG_W-1]) begin
      integ_new = integ_sum[INTEG_W-1:0];
    end else begin
      integ_new = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end
    derr = DERR_W'(err_r) - DERR_W'(last_r);
  end

  // pid saturation and torque clamp
  always_comb begin
    if (acc[ACC_W-1:PID_W-1] == '0 || acc[ACC_W-1:PID_W-1] == '1) begin
      pid_sat = acc[PID_W-1:0];
    end else begin
      pid_sat = acc[ACC_W-1] ? {1'b1, {(PID_W-1){1'b0}}} : {1'b0, {(PID_W-1){1'b1}}};
    end
    if (acc > $signed({{(ACC_W-GAIN_W){1'b0}}, cap_r})) begin
      torque_new = TORQUE_W'(cap_r);
    end else if (acc < $signed({{(ACC_W-TORQUE_W+1){1'b1}}, {(TORQUE_W-1){1'b0}}})) begin
      torque_new = {1'b1, {(TORQUE_W-1){1'b0}}};
    end else begin
      torque_new = acc[TORQUE_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (wheel_r == '0 || slip_sat) begin
          state_nxt = ST_ERR;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR:     state_nxt = ST_MUL_P;
      ST_MUL_P:   state_nxt = ST_MUL_I;
      ST_MUL_I:   state_nxt = ST_MUL_D;
      ST_MUL_D:   state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_PID;
      ST_PID:     state_nxt = ST_MUL_T;
      ST_MUL_T:   state_nxt = ST_TQ_WAIT;
      ST_TQ_WAIT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mac_op    = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SETUP: begin
        div_start = (wheel_r != '0) && !slip_sat;
      end
      ST_MUL_P: begin
        mac_op = '{en: 1'b1, clear: 1'b1, wide: 1'b0};
        mul_a  = $signed({1'b0, kp_r});
        mul_b  = MUL_B_W'(err_r);
      end
      ST_MUL_I: begin
        mac_op = '{en: 1'b1, clear: 1'b0, wide: 1'b0};
        mul_a  = $signed({1'b0, ki_r});
        mul_b  = MUL_B_W'(integ_r);
      end
      ST_MUL_D: begin
        mac_op = '{en: 1'b1, clear: 1'b0, wide: 1'b0};
        mul_a  = $signed({1'b0, kd_r});
        mul_b  = MUL_B_W'(derr);
      end
      ST_MUL_T: begin
        mac_op = '{en: 1'b1, clear: 1'b1, wide: 1'b1};
        mul_a  = $signed({1'b0, cap_r});
        mul_b  = MUL_B_W'(pid_r);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive_torque = torque_r;
  assign out_ch.pid_value    = pid_out_r;
  assign out_ch.slip_error   = err_out_r;

  sptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (abs_diff),
    .divisor  (wheel_r),
    .done     (div_done),
    .quot     (quot)
  );

  sptc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .a     (mul_a),
    .b     (mul_b),
    .acc   (acc)
  );

  // control state, registers and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      target_r    <= TARGET_SLIP_RST;
      kp_r        <= PROP_GAIN_RST;
      ki_r        <= INTEG_GAIN_RST;
      kd_r        <= DERIV_GAIN_RST;
      cap_r       <= TORQUE_CAP_RST;
      integ_r     <= '0;
      last_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_SLIP: target_r <= cfg_data[TARGET_W-1:0];
          CFG_PROP_GAIN:   kp_r     <= cfg_data[GAIN_W-1:0];
          CFG_INTEG_GAIN:  ki_r     <= cfg_data[GAIN_W-1:0];
          CFG_DERIV_GAIN:  kd_r     <= cfg_data[GAIN_W-1:0];
          CFG_TORQUE_CAP:  cap_r    <= cfg_data[GAIN_W-1:0];
          default:         ;
        endcase
      end
      if (state_r == ST_MUL_P) begin
        integ_r <= integ_new;
      end
      if (state_r == ST_MUL_D) begin
        last_r <= err_r;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      wheel_r   <= in_ch.wheel_speed & SPEED_MASK;
      vehicle_r <= in_ch.vehicle_speed & SPEED_MASK;
    end
    if (state_r == ST_SETUP) begin
      neg_r <= diff[SPEED_W];
      if (wheel_r == '0) begin
        slip_r <= SLIP_ZERO_WHEEL;
      end else if (slip_sat) begin
        slip_r <= SLIP_MIN;
      end
    end
    if (state_r == ST_DIV && div_done) begin
      slip_r <= neg_r ? -quot_s : quot_s;
    end
    if (state_r == ST_ERR) begin
      err_r <= err_new;
    end
    if (state_r == ST_PID) begin
      pid_r <= pid_sat;
    end
    if (state_r == ST_OUT && out_free) begin
      torque_r  <= torque_new;
      pid_out_r <= pid_r;
      err_out_r <= err_r;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_SETUP)
    else $error("accepted transaction did not start the sequence");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result appeared without the final state");

  a_torque_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> torque_r <= $signed({{(TORQUE_W-GAIN_W){1'b0}}, cap_r}))
    else $error("torque above cap");

endmodule

`default_nettype wire
